// ===== src/order_statistic_counting_set_core_assert.svh =====
// Assertion macros shared by the order statistic counting set RTL.
`ifndef ORDER_STATISTIC_COUNTING_SET_CORE_ASSERT_SVH
`define ORDER_STATISTIC_COUNTING_SET_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OSCS_ASSERT_IMP(lbl, clk_s, rst_ns, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define OSCS_ASSERT_NXT(lbl, clk_s, rst_ns, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/oscs_pkg.sv =====
// Types and constants shared by the order statistic counting set files.
package oscs_pkg;

	localparam int OP_W   = 3;
	localparam int KEY_W  = 10;
	localparam int RANK_W = 31;
	localparam int ANS_W  = 31;
	localparam int NODE_W = 32;

	localparam logic [NODE_W-1:0] MAX_TOTAL = 32'h7FFF_FFFF;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT      = 3'd0,
		OP_ERASE_ALL   = 3'd1,
		OP_ERASE_ONE   = 3'd2,
		OP_COUNT       = 3'd3,
		OP_SIZE        = 3'd4,
		OP_RANK_OF_KEY = 3'd5,
		OP_KEY_AT_RANK = 3'd6
	} op_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRE_RD,
		ST_PRE_ACC,
		ST_DISPATCH,
		ST_UPD_RD,
		ST_UPD_WR,
		ST_DSC_RD,
		ST_DSC_CMP,
		ST_FINISH
	} state_t;

	typedef enum logic [1:0] {
		PH_TOTAL,
		PH_HI,
		PH_LO
	} phase_t;

	typedef struct packed {
		logic [OP_W-1:0]   operation;
		logic [KEY_W-1:0]  key;
		logic [RANK_W-1:0] rank;
	} cmd_t;

	typedef struct packed {
		logic [ANS_W-1:0] answer;
		logic             found;
		logic             error;
	} rsp_t;

	typedef struct packed {
		logic [NODE_W-1:0] a;
		logic [NODE_W-1:0] b;
		logic              sub;
	} alu_req_t;

	typedef struct packed {
		logic [NODE_W-1:0] y;
		logic              carry;
	} alu_rsp_t;

endpackage

// ===== src/oscs_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
interface oscs_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/oscs_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module oscs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/oscs_alu.sv =====
// Shared 32-bit add/subtract unit with carry out used by the sequencer.
module oscs_alu import oscs_pkg::*; (
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	localparam int SUM_W = NODE_W + 1;

	logic [NODE_W-1:0] b_op;
	logic [SUM_W-1:0]  full;

	assign b_op    = req.sub ? ~req.b : req.b;
	assign full    = {1'b0, req.a} + {1'b0, b_op} + SUM_W'(req.sub);
	assign rsp.y     = full[NODE_W-1:0];
	assign rsp.carry = full[NODE_W];

endmodule

// ===== src/order_statistic_counting_set_core.sv =====
// Top level of the order statistic counting set, a multiset kept as a Fenwick tree of counts.
// The cmd channel takes one beat per operation (operation, key, rank); the res channel
// returns exactly one beat per command (answer, found, error), in command order.
// Counts live in one RAM of SIZE 32-bit tree nodes with one read and one write port.
// A small sequencer drives that RAM and a single shared 32-bit adder: every command
// first sums the whole set, then walks prefix sums, node updates or the rank descent
// one tree node at a time, each node taking a RAM read and then an add, write or compare.
// cmd.ready is low while a command is in work and rises in the cycle after the
// result is loaded. After reset a clearing pass writes zero to every node, and no
// command is taken until it ends. A finished result sits in an output register; the
// next command is accepted while it waits, but that command cannot finish until the
// receiver takes the pending beat.
`include "order_statistic_counting_set_core_assert.svh"

module order_statistic_counting_set_core import oscs_pkg::*; #(
	parameter int SIZE = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	oscs_stream_if.sink   cmd,
	oscs_stream_if.source res
);

	localparam int IW = $clog2(SIZE);
	localparam int AW = IW + 1;
	localparam logic [IW-1:0] STEP_TOP = IW'(1) << (IW - 1);

	state_t            state_q, state_d;
	phase_t            phase_q, phase_d;
	logic [OP_W-1:0]   op_q, op_d;
	logic [KEY_W-1:0]  key_q, key_d;
	logic [RANK_W-1:0] rank_q, rank_d;
	logic [AW-1:0]     e_q, e_d;
	logic [AW-1:0]     p_q, p_d;
	logic [AW-1:0]     q_q, q_d;
	logic [IW-1:0]     step_q, step_d;
	logic [IW-1:0]     clr_q, clr_d;
	logic [NODE_W-1:0] acc_q, acc_d;
	logic [NODE_W-1:0] hi_q, hi_d;
	logic [NODE_W-1:0] delta_q, delta_d;
	logic [NODE_W-1:0] rem_q, rem_d;
	logic [ANS_W-1:0]  r_ans_q, r_ans_d;
	logic              r_found_q, r_found_d;
	logic              r_err_q, r_err_d;
	rsp_t              res_q;
	logic              res_valid_q;
	logic              rsp_load;
	logic              cmd_ready;

	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	logic [NODE_W-1:0] ram_wdata;
	logic [IW-1:0]     ram_raddr;
	logic [NODE_W-1:0] ram_rdata;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;

	logic [31:0]       key_w;
	logic              in_range;
	logic [AW-1:0]     key_a;
	logic [AW-1:0]     e_dec;
	logic [AW-1:0]     node;

	oscs_ram #(
		.WIDTH(NODE_W),
		.DEPTH(SIZE)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	oscs_alu u_alu (
		.req(alu_req),
		.rsp(alu_rsp)
	);

	assign key_w    = 32'(key_q);
	assign in_range = key_w < 32'(SIZE);
	assign key_a    = key_w[AW-1:0];
	assign e_dec    = e_q - AW'(1);
	assign node     = q_q + AW'(step_q) - AW'(1);

	assign cmd.ready = cmd_ready;
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		op_d      = op_q;
		key_d     = key_q;
		rank_d    = rank_q;
		e_d       = e_q;
		p_d       = p_q;
		q_d       = q_q;
		step_d    = step_q;
		clr_d     = clr_q;
		acc_d     = acc_q;
		hi_d      = hi_q;
		delta_d   = delta_q;
		rem_d     = rem_q;
		r_ans_d   = r_ans_q;
		r_found_d = r_found_q;
		r_err_d   = r_err_q;
		rsp_load  = 1'b0;
		cmd_ready = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = p_q[IW-1:0];
		ram_wdata = alu_rsp.y;
		ram_raddr = '0;
		alu_req   = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + IW'(1);
				if (clr_q == IW'(SIZE - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				cmd_ready = 1'b1;
				if (cmd.valid) begin
					op_d    = cmd.data.operation;
					key_d   = cmd.data.key;
					rank_d  = cmd.data.rank;
					phase_d = PH_TOTAL;
					e_d     = AW'(SIZE);
					acc_d   = '0;
					state_d = ST_PRE_RD;
				end
			end
			ST_PRE_RD: begin
				if (e_q == '0) begin
					state_d = ST_DISPATCH;
				end else begin
					ram_raddr = e_dec[IW-1:0];
					e_d       = e_q & e_dec;
					state_d   = ST_PRE_ACC;
				end
			end
			ST_PRE_ACC: begin
				alu_req = '{a: acc_q, b: ram_rdata, sub: 1'b0};
				acc_d   = alu_rsp.y;
				state_d = ST_PRE_RD;
			end
			ST_DISPATCH: begin
				case (phase_q)
					PH_TOTAL: begin
						alu_req   = '{a: {1'b0, rank_q}, b: acc_q, sub: 1'b1};
						rem_d     = acc_q;
						r_ans_d   = '0;
						r_found_d = 1'b0;
						r_err_d   = 1'b0;
						state_d   = ST_FINISH;
						case (op_q)
							OP_INSERT: begin
								if (!in_range || acc_q >= MAX_TOTAL) begin
									r_err_d = 1'b1;
								end else begin
									delta_d = NODE_W'(1);
									p_d     = key_a;
									state_d = ST_UPD_RD;
								end
							end
							OP_ERASE_ALL, OP_ERASE_ONE, OP_COUNT: begin
								if (in_range) begin
									phase_d = PH_HI;
									e_d     = key_a + AW'(1);
									acc_d   = '0;
									state_d = ST_PRE_RD;
								end else begin
									r_err_d = (op_q != OP_COUNT);
								end
							end
							OP_SIZE: begin
								r_ans_d = acc_q[ANS_W-1:0];
							end
							OP_RANK_OF_KEY: begin
								if (in_range) begin
									phase_d = PH_LO;
									e_d     = key_a;
									acc_d   = '0;
									state_d = ST_PRE_RD;
								end else begin
									r_ans_d = acc_q[ANS_W-1:0];
								end
							end
							OP_KEY_AT_RANK: begin
								if (!alu_rsp.carry) begin
									rem_d   = {1'b0, rank_q};
									q_d     = '0;
									step_d  = STEP_TOP;
									state_d = ST_DSC_RD;
								end
							end
							default: begin
							end
						endcase
					end
					PH_HI: begin
						hi_d    = acc_q;
						phase_d = PH_LO;
						e_d     = key_a;
						acc_d   = '0;
						state_d = ST_PRE_RD;
					end
					PH_LO: begin
						if (op_q == OP_COUNT) begin
							alu_req = '{a: hi_q, b: acc_q, sub: 1'b1};
						end else begin
							alu_req = '{a: acc_q, b: hi_q, sub: 1'b1};
						end
						state_d = ST_FINISH;
						case (op_q)
							OP_COUNT: begin
								r_ans_d = alu_rsp.y[ANS_W-1:0];
							end
							OP_RANK_OF_KEY: begin
								r_ans_d = acc_q[ANS_W-1:0];
							end
							OP_ERASE_ALL: begin
								delta_d = alu_rsp.y;
								p_d     = key_a;
								state_d = ST_UPD_RD;
							end
							OP_ERASE_ONE: begin
								if (hi_q == acc_q) begin
									r_err_d = 1'b1;
								end else begin
									delta_d = '1;
									p_d     = key_a;
									state_d = ST_UPD_RD;
								end
							end
							default: begin
							end
						endcase
					end
					default: begin
						state_d = ST_FINISH;
					end
				endcase
			end
			ST_UPD_RD: begin
				if (p_q >= AW'(SIZE)) begin
					state_d = ST_FINISH;
				end else begin
					ram_raddr = p_q[IW-1:0];
					state_d   = ST_UPD_WR;
				end
			end
			ST_UPD_WR: begin
				alu_req = '{a: ram_rdata, b: delta_q, sub: 1'b0};
				ram_we  = 1'b1;
				p_d     = p_q | (p_q + AW'(1));
				state_d = ST_UPD_RD;
			end
			ST_DSC_RD: begin
				if (step_q == '0) begin
					r_ans_d   = ANS_W'(q_q);
					r_found_d = 1'b1;
					state_d   = ST_FINISH;
				end else if (node >= AW'(SIZE)) begin
					step_d = step_q >> 1;
				end else begin
					ram_raddr = node[IW-1:0];
					state_d   = ST_DSC_CMP;
				end
			end
			ST_DSC_CMP: begin
				alu_req = '{a: rem_q, b: ram_rdata, sub: 1'b1};
				if (alu_rsp.carry) begin
					rem_d = alu_rsp.y;
					q_d   = q_q + AW'(step_q);
				end
				step_d  = step_q >> 1;
				state_d = ST_DSC_RD;
			end
			ST_FINISH: begin
				if (!res_valid_q || res.ready) begin
					rsp_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			if (rsp_load) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		phase_q   <= phase_d;
		op_q      <= op_d;
		key_q     <= key_d;
		rank_q    <= rank_d;
		e_q       <= e_d;
		p_q       <= p_d;
		q_q       <= q_d;
		step_q    <= step_d;
		acc_q     <= acc_d;
		hi_q      <= hi_d;
		delta_q   <= delta_d;
		rem_q     <= rem_d;
		r_ans_q   <= r_ans_d;
		r_found_q <= r_found_d;
		r_err_q   <= r_err_d;
		if (rsp_load) begin
			res_q <= '{answer: r_ans_q, found: r_found_q, error: r_err_q};
		end
	end

	`OSCS_ASSERT_NXT(a_accept_leaves_idle, clk, arst_n, cmd.valid && cmd.ready,
		state_q != ST_IDLE, "accepted command did not start work")
	`OSCS_ASSERT_IMP(a_update_in_range, clk, arst_n, state_q == ST_UPD_WR,
		p_q < AW'(SIZE), "tree update addressed a node beyond the tree")
	`OSCS_ASSERT_IMP(a_found_xor_error, clk, arst_n, res_valid_q,
		!(res_q.found && res_q.error), "result has both found and error set")
	`OSCS_ASSERT_IMP(a_found_key_range, clk, arst_n, res_valid_q && res_q.found,
		32'(res_q.answer) < 32'(SIZE), "found key lies outside the key range")

endmodule
